[rtl/particle_record_update_defines.svh]
// Assertion macros for the particle record update block.
// No dependencies; included by the files that carry assertions.
`ifndef PARTICLE_RECORD_UPDATE_DEFINES_SVH
`define PARTICLE_RECORD_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("prupd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("prupd assertion failed");

`endif

[rtl/prupd_pkg.sv]
// Shared types, constants and helpers for the particle record update pipeline.
// No dependencies.
package prupd_pkg;

    localparam int LANE_W    = 32;
    localparam int HALF_W    = 16;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int COL_SUM_W = CH_W + 2;
    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    typedef enum logic [1:0] {
        KIND_FREE,
        KIND_LIVE,
        KIND_RELEASE
    } t_kind;

    typedef struct packed {
        logic [LANE_W-1:0]        life_word;
        logic signed [HALF_W-1:0] obj_slot;
        logic [2*LANE_W-1:0]      pos_xy;
        logic [LANE_W-1:0]        pos_z;
        logic [2*LANE_W-1:0]      vel_xy;
        logic [LANE_W-1:0]        vel_z;
        logic [2*LANE_W-1:0]      acc_xy;
        logic [LANE_W-1:0]        acc_z;
        logic [LANE_W-1:0]        tex_uv;
        logic [LANE_W-1:0]        tex_uv_step;
        logic [LANE_W-1:0]        color_in;
        logic [NUM_CH*CH_W-1:0]   color_step;
    } t_rec_in;

    typedef struct packed {
        t_kind   kind;
        t_rec_in rec;
    } t_rec_dec;

    typedef struct packed {
        t_kind                                kind;
        t_rec_in                              rec;
        logic [2*LANE_W-1:0]                  pos_xy_sum;
        logic [LANE_W-1:0]                    pos_z_sum;
        logic [2*LANE_W-1:0]                  vel_xy_sum;
        logic [LANE_W-1:0]                    vel_z_sum;
        logic [LANE_W-1:0]                    uv_sum;
        logic [HALF_W-1:0]                    rem_dec;
        logic [NUM_CH-1:0][COL_SUM_W-1:0]     col_sum;
    } t_rec_sum;

    typedef struct packed {
        logic [LANE_W-1:0]        life_out;
        logic signed [HALF_W-1:0] slot_out;
        logic [2*LANE_W-1:0]      pos_xy_out;
        logic [LANE_W-1:0]        pos_z_out;
        logic [2*LANE_W-1:0]      vel_xy_out;
        logic [LANE_W-1:0]        vel_z_out;
        logic [LANE_W-1:0]        tex_uv_out;
        logic [LANE_W-1:0]        color_out;
        logic                     release_res;
        logic signed [HALF_W-1:0] release_slot;
    } t_rec_out;

    // Clamp a signed channel sum to 0..255.
    function automatic logic [CH_W-1:0] sat_ch(input logic [COL_SUM_W-1:0] sum);
        logic [CH_W-1:0] res;
        if (sum[COL_SUM_W-1]) begin
            res = '0;
        end else if (sum[COL_SUM_W-2:CH_W] != '0) begin
            res = CH_MAX;
        end else begin
            res = sum[CH_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/prupd_if.sv]
// Valid/ready channel interfaces for particle records in and updated records out.
// No dependencies.
interface prupd_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        life_word;
    logic signed [15:0] obj_slot;
    logic [63:0]        pos_xy;
    logic [31:0]        pos_z;
    logic [63:0]        vel_xy;
    logic [31:0]        vel_z;
    logic [63:0]        acc_xy;
    logic [31:0]        acc_z;
    logic [31:0]        tex_uv;
    logic [31:0]        tex_uv_step;
    logic [31:0]        color_in;
    logic [23:0]        color_step;

    modport source (
        output valid, life_word, obj_slot, pos_xy, pos_z, vel_xy, vel_z,
               acc_xy, acc_z, tex_uv, tex_uv_step, color_in, color_step,
        input  ready
    );
    modport sink (
        input  valid, life_word, obj_slot, pos_xy, pos_z, vel_xy, vel_z,
               acc_xy, acc_z, tex_uv, tex_uv_step, color_in, color_step,
        output ready
    );
endinterface

interface prupd_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        life_out;
    logic signed [15:0] slot_out;
    logic [63:0]        pos_xy_out;
    logic [31:0]        pos_z_out;
    logic [63:0]        vel_xy_out;
    logic [31:0]        vel_z_out;
    logic [31:0]        tex_uv_out;
    logic [31:0]        color_out;
    logic               release_res;
    logic signed [15:0] release_slot;

    modport source (
        output valid, life_out, slot_out, pos_xy_out, pos_z_out, vel_xy_out,
               vel_z_out, tex_uv_out, color_out, release_res, release_slot,
        input  ready
    );
    modport sink (
        input  valid, life_out, slot_out, pos_xy_out, pos_z_out, vel_xy_out,
               vel_z_out, tex_uv_out, color_out, release_res, release_slot,
        output ready
    );
endinterface

[rtl/prupd_classify.sv]
// Stage 1: registers the incoming record and classifies it as free, live or released.
// Depends on prupd_pkg.
module prupd_classify import prupd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_rec_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_rec_dec o_data
);

    logic              r_vld;
    t_rec_dec          r_data;
    t_rec_dec          n_data;
    logic [HALF_W-1:0] owner;
    logic [HALF_W-1:0] rem;

    assign owner = i_data.life_word[LANE_W-1:HALF_W];
    assign rem   = i_data.life_word[HALF_W-1:0];

    always_comb begin
        n_data.rec = i_data;
        if (owner == '0) begin
            n_data.kind = KIND_FREE;
        end else if (rem != '0 && !rem[HALF_W-1]) begin
            n_data.kind = KIND_LIVE;
        end else begin
            n_data.kind = KIND_RELEASE;
        end
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

[rtl/prupd_sum.sv]
// Stage 2: lane adders for position, velocity, texture coordinates, color and life.
// Depends on prupd_pkg.
module prupd_sum import prupd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_rec_dec i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_rec_sum o_data
);

    logic     r_vld;
    t_rec_sum r_data;
    t_rec_sum n_data;
    t_rec_in  rec;

    assign rec = i_data.rec;

    always_comb begin
        logic [CH_W-1:0] base;
        logic [CH_W-1:0] step;
        n_data.kind = i_data.kind;
        n_data.rec  = rec;
        n_data.pos_xy_sum = {rec.pos_xy[2*LANE_W-1:LANE_W] + rec.vel_xy[2*LANE_W-1:LANE_W],
                             rec.pos_xy[LANE_W-1:0] + rec.vel_xy[LANE_W-1:0]};
        n_data.pos_z_sum  = rec.pos_z + rec.vel_z;
        n_data.vel_xy_sum = {rec.vel_xy[2*LANE_W-1:LANE_W] + rec.acc_xy[2*LANE_W-1:LANE_W],
                             rec.vel_xy[LANE_W-1:0] + rec.acc_xy[LANE_W-1:0]};
        n_data.vel_z_sum  = rec.vel_z + rec.acc_z;
        n_data.uv_sum = {rec.tex_uv[LANE_W-1:HALF_W] + rec.tex_uv_step[LANE_W-1:HALF_W],
                         rec.tex_uv[HALF_W-1:0] + rec.tex_uv_step[HALF_W-1:0]};
        n_data.rem_dec = rec.life_word[HALF_W-1:0] - HALF_W'(1);
        for (int c = 0; c < NUM_CH; c++) begin
            base = rec.color_in[c*CH_W +: CH_W];
            step = rec.color_step[c*CH_W +: CH_W];
            // unsigned byte plus sign-extended delta
            n_data.col_sum[c] = {2'b00, base} + {{2{step[CH_W-1]}}, step};
        end
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

[rtl/prupd_finish.sv]
// Stage 3: color saturation and result select; holds the output register.
// Depends on prupd_pkg.
module prupd_finish import prupd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_rec_sum i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_rec_out o_data
);

    logic     r_vld;
    t_rec_out r_data;
    t_rec_out n_data;
    t_rec_in  rec;

    assign rec = i_data.rec;

    always_comb begin
        // pass-through by default (free record)
        n_data.life_out     = rec.life_word;
        n_data.slot_out     = rec.obj_slot;
        n_data.pos_xy_out   = rec.pos_xy;
        n_data.pos_z_out    = rec.pos_z;
        n_data.vel_xy_out   = rec.vel_xy;
        n_data.vel_z_out    = rec.vel_z;
        n_data.tex_uv_out   = rec.tex_uv;
        n_data.color_out    = rec.color_in;
        n_data.release_res  = 1'b0;
        n_data.release_slot = '0;
        case (i_data.kind)
            KIND_LIVE: begin
                n_data.life_out   = {rec.life_word[LANE_W-1:HALF_W], i_data.rem_dec};
                n_data.pos_xy_out = i_data.pos_xy_sum;
                n_data.pos_z_out  = i_data.pos_z_sum;
                n_data.vel_xy_out = i_data.vel_xy_sum;
                n_data.vel_z_out  = i_data.vel_z_sum;
                n_data.tex_uv_out = i_data.uv_sum;
                n_data.color_out  = {rec.color_in[LANE_W-1:NUM_CH*CH_W],
                                     sat_ch(i_data.col_sum[2]),
                                     sat_ch(i_data.col_sum[1]),
                                     sat_ch(i_data.col_sum[0])};
            end
            KIND_RELEASE: begin
                n_data.life_out     = '0;
                n_data.slot_out     = '0;
                n_data.release_res  = 1'b1;
                n_data.release_slot = rec.obj_slot;
            end
            default: begin
            end
        endcase
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

[rtl/particle_record_update.sv]
// Top level of the particle record update block: three-stage record pipeline.
// Depends on prupd_pkg, prupd_if, prupd_classify, prupd_sum, prupd_finish and the defines header.
//
//   channel  | dir | contents
//   ---------+-----+----------------------------------------------
//   i_rec    | in  | one particle record per transaction
//   o_rec    | out | updated record plus release event, one per input
//
// Three register stages (classify, add, select): a record accepted into the classify
// register passes through the add and select registers to o_rec. One record is
// taken every cycle while o_rec does not stall, since every stage can load while it unloads.
// Each stage advances when empty or when the stage after it advances, so a stall
// at o_rec backs up stage by stage and nothing is dropped or repeated.
// Synchronous active-low reset empties all stages; there is no state to clear.
`include "particle_record_update_defines.svh"

module particle_record_update import prupd_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    prupd_in_if.sink    i_rec,
    prupd_out_if.source o_rec
);

    t_rec_in  in_data;
    t_rec_dec dec_data;
    t_rec_sum sum_data;
    t_rec_out out_data;
    logic     dec_valid;
    logic     dec_ready;
    logic     sum_valid;
    logic     sum_ready;

    always_comb begin
        in_data.life_word   = i_rec.life_word;
        in_data.obj_slot    = i_rec.obj_slot;
        in_data.pos_xy      = i_rec.pos_xy;
        in_data.pos_z       = i_rec.pos_z;
        in_data.vel_xy      = i_rec.vel_xy;
        in_data.vel_z       = i_rec.vel_z;
        in_data.acc_xy      = i_rec.acc_xy;
        in_data.acc_z       = i_rec.acc_z;
        in_data.tex_uv      = i_rec.tex_uv;
        in_data.tex_uv_step = i_rec.tex_uv_step;
        in_data.color_in    = i_rec.color_in;
        in_data.color_step  = i_rec.color_step;
    end

    prupd_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rec.valid),
        .o_ready (i_rec.ready),
        .i_data  (in_data),
        .o_valid (dec_valid),
        .i_ready (dec_ready),
        .o_data  (dec_data)
    );

    prupd_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_data  (dec_data),
        .o_valid (sum_valid),
        .i_ready (sum_ready),
        .o_data  (sum_data)
    );

    prupd_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (sum_ready),
        .i_data  (sum_data),
        .o_valid (o_rec.valid),
        .i_ready (o_rec.ready),
        .o_data  (out_data)
    );

    assign o_rec.life_out     = out_data.life_out;
    assign o_rec.slot_out     = out_data.slot_out;
    assign o_rec.pos_xy_out   = out_data.pos_xy_out;
    assign o_rec.pos_z_out    = out_data.pos_z_out;
    assign o_rec.vel_xy_out   = out_data.vel_xy_out;
    assign o_rec.vel_z_out    = out_data.vel_z_out;
    assign o_rec.tex_uv_out   = out_data.tex_uv_out;
    assign o_rec.color_out    = out_data.color_out;
    assign o_rec.release_res  = out_data.release_res;
    assign o_rec.release_slot = out_data.release_slot;

    // released record carries a cleared life word and slot
    `PRU_ASSERT_NOW(a_release_clears, i_clk, i_rst_n, o_rec.valid && o_rec.release_res, o_rec.life_out == '0 && o_rec.slot_out == '0)
    // no release event means no slot named
    `PRU_ASSERT_NOW(a_no_release_slot, i_clk, i_rst_n, o_rec.valid && !o_rec.release_res, o_rec.release_slot == '0)
    // input back-pressure only when every stage is full and the output stalls
    `PRU_ASSERT_NOW(a_backpressure, i_clk, i_rst_n, !i_rec.ready, o_rec.valid && !o_rec.ready && dec_valid && sum_valid)
    // a stalled result stays valid into the next cycle
    `PRU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_rec.valid && !o_rec.ready, o_rec.valid)

endmodule

[tb/particle_record_update_test.sv]
// Self-checking testbench for particle_record_update: directed and random records,
// predicted updates checked field by field against every o_rec transaction.
// Depends on prupd_pkg, prupd_if and the particle_record_update RTL.
module particle_record_update_test;
    import prupd_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 12;
    localparam int RANDOM_RECS  = 600;

    typedef enum int {
        STALL_NONE,
        STALL_SENDER,
        STALL_RECEIVER,
        STALL_BOTH
    } t_stall_mode;

    logic i_clk;
    logic i_rst_n;

    prupd_in_if  rec_in ();
    prupd_out_if rec_out ();

    particle_record_update dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_in),
        .o_rec   (rec_out)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    t_rec_in     records_to_send[$];
    t_rec_out    pending_updates[$];
    t_stall_mode stall_mode = STALL_NONE;
    int          total_records;
    int          accepted_total;
    int          first_drain_at;
    int          second_drain_at;
    bit          hold_for_drain;
    int          mismatch_count;
    int          updates_checked;
    int          free_count;
    int          live_count;
    int          released_count;
    int          quiet_cycles;
    t_rec_in     record_on_bus;
    t_rec_in     next_record;
    t_rec_out    observed_update;
    t_kind       record_kind;

    // -------------------------------------------------------------------------
    // Update predictor
    // -------------------------------------------------------------------------
    function automatic logic [7:0] clamp_channel(input logic [7:0] base,
                                                 input logic [7:0] delta);
        int          total;
        logic [7:0]  res;
        total = int'(base) + int'($signed(delta));
        if (total < 0) begin
            res = 8'h00;
        end else if (total > 255) begin
            res = 8'hFF;
        end else begin
            res = total[7:0];
        end
        return res;
    endfunction

    function automatic t_rec_out predict_update(input t_rec_in r, output t_kind kind);
        t_rec_out   upd;
        logic [15:0] owner;
        logic [15:0] ticks;
        owner = r.life_word[31:16];
        ticks = r.life_word[15:0];

        // default: record copied through, no release event
        upd.life_out     = r.life_word;
        upd.slot_out     = r.obj_slot;
        upd.pos_xy_out   = r.pos_xy;
        upd.pos_z_out    = r.pos_z;
        upd.vel_xy_out   = r.vel_xy;
        upd.vel_z_out    = r.vel_z;
        upd.tex_uv_out   = r.tex_uv;
        upd.color_out    = r.color_in;
        upd.release_res  = 1'b0;
        upd.release_slot = '0;

        if (owner == 16'h0000) begin
            kind = KIND_FREE;
        end else if (ticks != 16'h0000 && !ticks[15]) begin
            kind = KIND_LIVE;
            // each 32-bit lane wraps on its own, no carry between x and y
            upd.pos_xy_out = {r.pos_xy[63:32] + r.vel_xy[63:32],
                              r.pos_xy[31:0] + r.vel_xy[31:0]};
            upd.pos_z_out  = r.pos_z + r.vel_z;
            upd.vel_xy_out = {r.vel_xy[63:32] + r.acc_xy[63:32],
                              r.vel_xy[31:0] + r.acc_xy[31:0]};
            upd.vel_z_out  = r.vel_z + r.acc_z;
            upd.tex_uv_out = {r.tex_uv[31:16] + r.tex_uv_step[31:16],
                              r.tex_uv[15:0] + r.tex_uv_step[15:0]};
            upd.color_out  = {r.color_in[31:24],
                              clamp_channel(r.color_in[23:16], r.color_step[23:16]),
                              clamp_channel(r.color_in[15:8], r.color_step[15:8]),
                              clamp_channel(r.color_in[7:0], r.color_step[7:0])};
            upd.life_out   = {owner, ticks - 16'd1};
        end else begin
            kind = KIND_RELEASE;
            upd.life_out     = '0;
            upd.slot_out     = '0;
            upd.release_res  = 1'b1;
            upd.release_slot = r.obj_slot;
        end
        return upd;
    endfunction

    // -------------------------------------------------------------------------
    // Stimulus helpers
    // -------------------------------------------------------------------------
    function automatic t_rec_in random_record();
        t_rec_in r;
        r.life_word   = $urandom;
        r.obj_slot    = 16'($urandom);
        r.pos_xy      = {$urandom, $urandom};
        r.pos_z       = $urandom;
        r.vel_xy      = {$urandom, $urandom};
        r.vel_z       = $urandom;
        r.acc_xy      = {$urandom, $urandom};
        r.acc_z       = $urandom;
        r.tex_uv      = $urandom;
        r.tex_uv_step = $urandom;
        r.color_in    = $urandom;
        r.color_step  = 24'($urandom);
        return r;
    endfunction

    // Mostly live records so the add and saturation paths see most traffic.
    function automatic logic [31:0] random_life_word();
        logic [15:0] owner;
        logic [15:0] ticks;
        int          pick;
        owner = 16'($urandom_range(16'hFFFF, 1));
        pick  = $urandom_range(99);
        if (pick < 20) begin
            owner = 16'h0000;
            ticks = 16'($urandom);
        end else if (pick < 75) begin
            case ($urandom_range(3))
                0: begin
                    ticks = 16'd1;
                end
                1: begin
                    ticks = 16'h7FFF;
                end
                2: begin
                    ticks = 16'($urandom_range(4, 1));
                end
                default: begin
                    ticks = 16'($urandom_range(16'h7FFF, 1));
                end
            endcase
        end else if (pick < 85) begin
            ticks = 16'h0000;
        end else begin
            ticks = 16'($urandom_range(16'hFFFF, 16'h8000));
        end
        return {owner, ticks};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at update %0d: %s got %h expected %h",
                 updates_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_update(input t_rec_out got, input t_rec_out want);
        if (got.life_out !== want.life_out)
            report_mismatch("life_out", got.life_out, want.life_out);
        if (got.slot_out !== want.slot_out)
            report_mismatch("slot_out", got.slot_out, want.slot_out);
        if (got.pos_xy_out !== want.pos_xy_out)
            report_mismatch("pos_xy_out", got.pos_xy_out, want.pos_xy_out);
        if (got.pos_z_out !== want.pos_z_out)
            report_mismatch("pos_z_out", got.pos_z_out, want.pos_z_out);
        if (got.vel_xy_out !== want.vel_xy_out)
            report_mismatch("vel_xy_out", got.vel_xy_out, want.vel_xy_out);
        if (got.vel_z_out !== want.vel_z_out)
            report_mismatch("vel_z_out", got.vel_z_out, want.vel_z_out);
        if (got.tex_uv_out !== want.tex_uv_out)
            report_mismatch("tex_uv_out", got.tex_uv_out, want.tex_uv_out);
        if (got.color_out !== want.color_out)
            report_mismatch("color_out", got.color_out, want.color_out);
        if (got.release_res !== want.release_res)
            report_mismatch("release_res", got.release_res, want.release_res);
        if (got.release_slot !== want.release_slot)
            report_mismatch("release_slot", got.release_slot, want.release_slot);
    endtask

    // -------------------------------------------------------------------------
    // Driver: presents queued records on i_rec
    // -------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rec_in.valid <= 1'b0;
        end else begin
            if (rec_in.valid && rec_in.ready) begin
                pending_updates.push_back(predict_update(record_on_bus, record_kind));
                case (record_kind)
                    KIND_FREE: begin
                        free_count++;
                    end
                    KIND_LIVE: begin
                        live_count++;
                    end
                    default: begin
                        released_count++;
                    end
                endcase
                accepted_total++;
                if (accepted_total == first_drain_at || accepted_total == second_drain_at)
                    hold_for_drain = 1'b1;
                if (accepted_total * 4 / total_records >= 3)
                    stall_mode <= STALL_BOTH;
                else
                    stall_mode <= t_stall_mode'(accepted_total * 4 / total_records);
            end
            if (!rec_in.valid || rec_in.ready) begin
                if (hold_for_drain && pending_updates.size() != 0) begin
                    rec_in.valid <= 1'b0;
                end else if (records_to_send.size() != 0
                             && !(stall_mode == STALL_SENDER && $urandom_range(99) < 64)
                             && !(stall_mode == STALL_BOTH && $urandom_range(99) < 21)) begin
                    hold_for_drain = 1'b0;
                    next_record    = records_to_send.pop_front();
                    record_on_bus  = next_record;
                    rec_in.valid       <= 1'b1;
                    rec_in.life_word   <= next_record.life_word;
                    rec_in.obj_slot    <= next_record.obj_slot;
                    rec_in.pos_xy      <= next_record.pos_xy;
                    rec_in.pos_z       <= next_record.pos_z;
                    rec_in.vel_xy      <= next_record.vel_xy;
                    rec_in.vel_z       <= next_record.vel_z;
                    rec_in.acc_xy      <= next_record.acc_xy;
                    rec_in.acc_z       <= next_record.acc_z;
                    rec_in.tex_uv      <= next_record.tex_uv;
                    rec_in.tex_uv_step <= next_record.tex_uv_step;
                    rec_in.color_in    <= next_record.color_in;
                    rec_in.color_step  <= next_record.color_step;
                end else begin
                    hold_for_drain = 1'b0;
                    rec_in.valid <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // Monitor: takes o_rec transactions and checks them in order
    // -------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rec_out.ready <= 1'b0;
        end else begin
            if (rec_out.valid && rec_out.ready) begin
                observed_update.life_out     = rec_out.life_out;
                observed_update.slot_out     = rec_out.slot_out;
                observed_update.pos_xy_out   = rec_out.pos_xy_out;
                observed_update.pos_z_out    = rec_out.pos_z_out;
                observed_update.vel_xy_out   = rec_out.vel_xy_out;
                observed_update.vel_z_out    = rec_out.vel_z_out;
                observed_update.tex_uv_out   = rec_out.tex_uv_out;
                observed_update.color_out    = rec_out.color_out;
                observed_update.release_res  = rec_out.release_res;
                observed_update.release_slot = rec_out.release_slot;
                if (pending_updates.size() == 0) begin
                    report_mismatch("result with none pending", observed_update.life_out, '0);
                end else begin
                    check_update(observed_update, pending_updates.pop_front());
                end
                updates_checked++;
            end
            case (stall_mode)
                STALL_RECEIVER: begin
                    rec_out.ready <= ($urandom_range(99) >= 64);
                end
                STALL_BOTH: begin
                    rec_out.ready <= ($urandom_range(99) >= 21);
                end
                default: begin
                    rec_out.ready <= 1'b1;
                end
            endcase
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (rec_in.valid && rec_in.ready) || (rec_out.valid && rec_out.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transaction for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // -------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // -------------------------------------------------------------------------
    initial begin
        t_rec_in r;

        i_rst_n            = 1'b0;
        rec_in.valid       = 1'b0;
        rec_in.life_word   = '0;
        rec_in.obj_slot    = '0;
        rec_in.pos_xy      = '0;
        rec_in.pos_z       = '0;
        rec_in.vel_xy      = '0;
        rec_in.vel_z       = '0;
        rec_in.acc_xy      = '0;
        rec_in.acc_z       = '0;
        rec_in.tex_uv      = '0;
        rec_in.tex_uv_step = '0;
        rec_in.color_in    = '0;
        rec_in.color_step  = '0;
        rec_out.ready      = 1'b0;
        mismatch_count     = 0;
        updates_checked    = 0;
        accepted_total     = 0;
        hold_for_drain     = 1'b0;
        free_count         = 0;
        live_count         = 0;
        released_count     = 0;

        // free record, all zero
        r = '0;
        records_to_send.push_back(r);
        // free record, everything else all ones
        r = '1;
        r.life_word = 32'h0000_FFFF;
        records_to_send.push_back(r);
        // live, all lanes wrap, every channel saturates high
        r = '1;
        r.life_word  = 32'h0001_0001;
        r.color_in   = 32'hA5FF_FFFF;
        r.color_step = 24'h7F7F7F;
        records_to_send.push_back(r);
        // live, largest tick count, every channel saturates low
        r = random_record();
        r.life_word  = 32'hFFFF_7FFF;
        r.obj_slot   = 16'sh7FFF;
        r.color_in   = 32'h5A00_0000;
        r.color_step = 24'h808080;
        records_to_send.push_back(r);
        // live, negative owner; carries must stay inside their lane
        r = '0;
        r.life_word   = 32'h8000_0001;
        r.obj_slot    = -16'sd32768;
        r.pos_xy      = 64'h0000_0000_FFFF_FFFF;
        r.vel_xy      = 64'h0000_0000_0000_0001;
        r.acc_xy      = 64'hFFFF_FFFF_FFFF_FFFF;
        r.pos_z       = 32'hFFFF_FFFF;
        r.vel_z       = 32'h0000_0001;
        r.tex_uv      = 32'hFFFF_FFFF;
        r.tex_uv_step = 32'h0001_0001;
        r.color_in    = 32'h00FF_0180;
        r.color_step  = 24'h01FF7F;
        records_to_send.push_back(r);
        // release: zero ticks, most negative ticks, minus one ticks
        r = random_record();
        r.life_word  = 32'h0001_0000;
        r.obj_slot   = 16'sh7FFF;
        records_to_send.push_back(r);
        r = random_record();
        r.life_word  = 32'hFFFF_8000;
        r.obj_slot   = -16'sd32768;
        records_to_send.push_back(r);
        r = random_record();
        r.life_word  = 32'h7FFF_FFFF;
        r.obj_slot   = -16'sd1;
        records_to_send.push_back(r);
        // free record whose tick half would otherwise mean release
        r = random_record();
        r.life_word = 32'h0000_8000;
        records_to_send.push_back(r);
        // live with zero deltas: only the tick count moves
        r = random_record();
        r.life_word   = 32'h0042_0002;
        r.vel_xy      = '0;
        r.vel_z       = '0;
        r.acc_xy      = '0;
        r.acc_z       = '0;
        r.tex_uv_step = '0;
        r.color_step  = '0;
        records_to_send.push_back(r);
        for (int k = 0; k < 6; k++) begin
            r = random_record();
            r.life_word = random_life_word();
            records_to_send.push_back(r);
        end
        first_drain_at = records_to_send.size();

        for (int k = 0; k < RANDOM_RECS; k++) begin
            r = random_record();
            r.life_word = random_life_word();
            records_to_send.push_back(r);
        end
        total_records   = records_to_send.size();
        second_drain_at = first_drain_at + RANDOM_RECS / 2;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (records_to_send.size() != 0 || rec_in.valid)
            @(negedge i_clk);
        while (pending_updates.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);

        if (pending_updates.size() != 0)
            report_mismatch("results never arrived", pending_updates.size(), '0);
        $display("sent %0d records (%0d free, %0d live, %0d released), checked %0d updates",
                 accepted_total, free_count, live_count, released_count, updates_checked);
        $display("idle phases: none, sender, receiver, both; %0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
